### rtl/rsw_pkg.sv
`timescale 1ns / 1ps

package rsw_pkg;

   // field and register widths
   localparam int WORD_W            = 32;
   localparam int VALUE_W           = 10;
   localparam int CFG_W             = 11;
   localparam int CSR_INDEX_W       = 4;
   localparam int MAX_ITEMS_DEFAULT = 1024;
   localparam int QUEUE_DEPTH       = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ITEMS_IN_USE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_PICKS_PER_ROUND = CSR_INDEX_W'(1);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_status_type;

endpackage

### rtl/random_sample_without_replacement.sv
`timescale 1ns / 1ps

// Draws distinct values from 0..n-1 by a partial Fisher-Yates pass over a
// permutation store of MAX_ITEMS entries. Each request carries one random
// word; the block answers with exactly one response strobe (rsp_valid high
// for one cycle) holding the drawn value and a flag on the last draw of a
// round. The receiver cannot stall, so responses must be taken when shown.
// A request is taken when start is high and busy is low. A draw runs the
// bit-serial modulo of the random word by position+1, then the
// read-read-write-write swap on the store (one read port, one write port),
// then hands the next request to the divider. A two-entry queue between
// the request side and the divider lets two further requests be taken
// while a draw is running. After reset, and after every write to a known
// register, the store is reloaded with the identity one entry a cycle, so
// busy stays high until the reload ends; register writes are always
// accepted.
module random_sample_without_replacement #(
   parameter int MAX_ITEMS = rsw_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              start,
   output logic                              busy,
   input  logic [rsw_pkg::WORD_W-1:0]        req_random_word,
   // response side
   output logic                              rsp_valid,
   output logic [rsw_pkg::VALUE_W-1:0]       rsp_picked_value,
   output logic                              rsp_round_done,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rsw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rsw_pkg::CFG_W-1:0]         csr_data
);
   import rsw_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int NW    = IDX_W + 1;
   localparam int JOB_W = WORD_W + IDX_W + 1;

   // configuration registers
   logic [CFG_W-1:0] items_ff, items_in;
   logic [CFG_W-1:0] picks_ff, picks_in;
   logic             csr_write;
   logic             restart;

   // effective population and picks, saturated
   logic [NW-1:0]    items_eff;
   logic [NW-1:0]    picks_eff;

   logic             req_accept;
   logic             push;
   logic             pop;
   logic [JOB_W-1:0] push_job;
   logic [JOB_W-1:0] head_job;
   queue_status_type q_status;
   back_status_type  b_status;

   // writes are taken at once
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // a write to a known register reloads the store and starts a fresh round
   assign restart   = csr_write &&
                      ((csr_index == REG_ITEMS_IN_USE) || (csr_index == REG_PICKS_PER_ROUND));

   always_comb begin
      items_in = items_ff;
      picks_in = picks_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ITEMS_IN_USE:    items_in = csr_data;
            REG_PICKS_PER_ROUND: picks_in = csr_data;
            default: begin
               items_in = items_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff <= CFG_W'(1024);
         picks_ff <= CFG_W'(1);
      end else begin
         items_ff <= items_in;
         picks_ff <= picks_in;
      end
   end

   // population of zero acts as one, capped at the store depth
   always_comb begin
      if (items_ff == '0) begin
         items_eff = NW'(1);
      end else if (32'(items_ff) > 32'(MAX_ITEMS)) begin
         items_eff = NW'(MAX_ITEMS);
      end else begin
         items_eff = NW'(items_ff);
      end
   end

   // picks held to one at least and to the population at most
   always_comb begin
      if (picks_ff == '0) begin
         picks_eff = NW'(1);
      end else if (32'(picks_ff) > 32'(items_eff)) begin
         picks_eff = items_eff;
      end else begin
         picks_eff = NW'(picks_ff);
      end
   end

   // no request while the store reloads, the queue is full or a write lands
   assign busy       = b_status.clearing || q_status.full || csr_valid;
   assign req_accept = start && !busy;

   // front: tracks position and round count, tags each request
   rsw_front #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .accept    (req_accept),
      .word      (req_random_word),
      .items_eff (items_eff),
      .picks_eff (picks_eff),
      .push      (push),
      .job       (push_job)
   );

   rsw_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .flush     (restart),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .head      (head_job),
      .status    (q_status)
   );

   // back: modulo, swap in the store, registered response
   rsw_back #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .job_ready        (!q_status.empty),
      .job              (head_job),
      .pop              (pop),
      .status           (b_status),
      .rsp_valid        (rsp_valid),
      .rsp_picked_value (rsp_picked_value),
      .rsp_round_done   (rsp_round_done)
   );

`ifndef SYNTHESIS
   // no response comes out while the store is being reloaded
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !b_status.clearing)
      else $error("response during store reload");

   // reload must hold requests off
   a_busy_in_clear: assert property (@(posedge clock) disable iff (reset)
      b_status.clearing |-> busy)
      else $error("busy low during store reload");

   // every draw runs the full modulo and swap, so strobes never touch
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // a taken request always finds room in the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !q_status.full)
      else $error("request taken with queue full");
`endif

endmodule

### rtl/rsw_ram.sv
`timescale 1ns / 1ps

module rsw_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/rsw_front.sv
`timescale 1ns / 1ps

module rsw_front #(
   parameter int MAX_ITEMS = rsw_pkg::MAX_ITEMS_DEFAULT,
   localparam int IDX_W = $clog2(MAX_ITEMS),
   localparam int NW = IDX_W + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic                      accept,
   input  logic [rsw_pkg::WORD_W-1:0] word,
   input  logic [NW-1:0]             items_eff,
   input  logic [NW-1:0]             picks_eff,
   output logic                      push,
   output logic [rsw_pkg::WORD_W+IDX_W:0] job
);
   import rsw_pkg::*;

   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [NW-1:0]    draws_ff, draws_in;
   logic             fresh_ff, fresh_in;
   logic [IDX_W-1:0] last_pos;
   logic [IDX_W-1:0] cur_pos;
   logic [NW-1:0]    draws_next;
   logic             done;

   // fresh round starts at the top of the population
   assign last_pos   = IDX_W'(items_eff - NW'(1));
   assign draws_next = draws_ff + NW'(1);
   assign done       = (draws_next >= picks_eff);

   always_comb begin
      if (fresh_ff || (NW'(pos_ff) >= items_eff)) begin
         cur_pos = last_pos;
      end else begin
         cur_pos = pos_ff;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      draws_in = draws_ff;
      fresh_in = fresh_ff;
      if (accept) begin
         if (done) begin
            draws_in = '0;
            fresh_in = 1'b1;
         end else begin
            draws_in = draws_next;
            fresh_in = 1'b0;
            pos_in   = (cur_pos != '0) ? cur_pos - IDX_W'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff   <= '0;
         draws_ff <= '0;
         fresh_ff <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         draws_ff <= draws_in;
         fresh_ff <= fresh_in;
      end
   end

   assign push = accept;
   assign job  = {word, cur_pos, done};

endmodule

### rtl/rsw_queue.sv
`timescale 1ns / 1ps

module rsw_queue #(
   parameter int WIDTH = 43
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      flush,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head,
   output rsw_pkg::queue_status_type status
);
   import rsw_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rsw_back.sv
`timescale 1ns / 1ps

module rsw_back #(
   parameter int MAX_ITEMS = rsw_pkg::MAX_ITEMS_DEFAULT,
   localparam int IDX_W = $clog2(MAX_ITEMS),
   localparam int NW = IDX_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          job_ready,
   input  logic [rsw_pkg::WORD_W+IDX_W:0] job,
   output logic                          pop,
   output rsw_pkg::back_status_type      status,
   output logic                          rsp_valid,
   output logic [rsw_pkg::VALUE_W-1:0]   rsp_picked_value,
   output logic                          rsp_round_done
);
   import rsw_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_RDJ   = 3'd3;
   localparam logic [2:0] S_RDP   = 3'd4;
   localparam logic [2:0] S_WRJ   = 3'd5;
   localparam logic [2:0] S_WRP   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [WORD_W-1:0]  dvd_ff, dvd_in;
   logic [NW:0]        rem_ff, rem_in;
   logic [NW-1:0]      dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               done_ff, done_in;
   logic [IDX_W-1:0]   vj_ff, vj_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [WORD_W-1:0]  job_word;
   logic [IDX_W-1:0]   job_pos;
   logic               job_done;
   logic [NW:0]        rem_sh;
   logic [IDX_W-1:0]   j_idx;
   logic [WORD_W-1:0]  vj_ext;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [IDX_W-1:0]   ram_wdata, ram_rdata;

   assign {job_word, job_pos, job_done} = job;

   // one restoring step per cycle
   assign rem_sh = {rem_ff[NW-1:0], dvd_ff[WORD_W-1]};
   assign j_idx  = rem_ff[IDX_W-1:0];
   assign vj_ext = WORD_W'(vj_ff);

   assign pop             = (state_ff == S_IDLE) && job_ready;
   assign status.clearing = (state_ff == S_CLEAR);
   assign status.idle     = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      vj_in        = vj_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_done_in  = rsp_done_ff;
      ram_we       = 1'b0;
      ram_waddr    = j_idx;
      ram_wdata    = ram_rdata;
      ram_raddr    = j_idx;
      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(MAX_ITEMS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_ready) begin
               dvd_in   = job_word;
               rem_in   = '0;
               dvs_in   = NW'(job_pos) + NW'(1);
               cnt_in   = '0;
               pos_in   = job_pos;
               done_in  = job_done;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
            end else begin
               rem_in = rem_sh;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            ram_raddr = j_idx;
            state_in  = S_RDP;
         end
         S_RDP: begin
            ram_raddr = pos_ff;
            vj_in     = ram_rdata;
            state_in  = S_WRJ;
         end
         S_WRJ: begin
            // entry at pos moves down to j
            ram_we    = 1'b1;
            ram_waddr = j_idx;
            ram_wdata = ram_rdata;
            state_in  = S_WRP;
         end
         S_WRP: begin
            ram_we       = 1'b1;
            ram_waddr    = pos_ff;
            ram_wdata    = vj_ff;
            rsp_valid_in = 1'b1;
            rsp_value_in = vj_ext[VALUE_W-1:0];
            rsp_done_in  = done_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      pos_ff       <= pos_in;
      done_ff      <= done_in;
      vj_ff        <= vj_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
   end

   rsw_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_value = rsp_value_ff;
   assign rsp_round_done   = rsp_done_ff;

endmodule
